[design/oes_pkg.sv]
// Shared constants, types and control structs for the odd-even sort pass counter.
package oes_pkg;

	localparam int MAX_ELEMENTS = 64;
	localparam int ELEMENT_BITS = 32;
	localparam int VALUE_BITS   = 32;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int PASS_BITS    = 7;
	localparam int PASS_MAX     = (1 << PASS_BITS) - 1;

	typedef logic signed [ELEMENT_BITS-1:0] elem_t;
	typedef logic signed [VALUE_BITS-1:0]   value_t;
	typedef logic [CNT_W-1:0]               count_t;
	typedef logic [PASS_BITS-1:0]           pass_count_t;

	typedef struct packed {
		logic load;
		logic start;
		logic pass;
		logic finish;
	} oes_cmd_t;

	typedef struct packed {
		logic done;
	} oes_sts_t;

endpackage

[design/oes_if.sv]
// Request channel interfaces for list elements and pass count results.
interface oes_in_if;
	import oes_pkg::*;

	logic   valid;
	logic   ready;
	value_t value;
	logic   last_item;

	modport source (output valid, output value, output last_item, input ready);
	modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface oes_out_if;
	import oes_pkg::*;

	logic        valid;
	logic        ready;
	pass_count_t pass_count;
	logic        overflow;

	modport source (output valid, output pass_count, output overflow, input ready);
	modport sink   (input valid, input pass_count, input overflow, output ready);
endinterface

[design/odd_even_sort_pass_counter_top.sv]
// Top level of the odd-even transposition sort pass counter.
// Usage:
//   in_ch carries one list element per request (value, last_item); the
//   request with last_item set closes the list. Elements beyond 64 are
//   dropped and flagged in the result's overflow bit.
//   out_ch carries one result per list: pass_count and overflow.
// Timing:
//   each accepted request loads one element. After the closing request the
//   block runs one sort pass per cycle, all pair comparators in parallel,
//   with the order check of the whole list in the same cycle; a list of
//   n elements needs at most n sort passes. The result is registered when
//   the sort finishes and the output register is free. in_ch.ready is
//   low while sorting.
// Stall: the result sits in an output register; the next list loads while it
//   waits, and a later sort holds at its end until that register is free.
// Reset: arst_n clears the counters, the flags and the result valid; the
//   element store is not cleared.
module odd_even_sort_pass_counter_top (
	input logic clk,
	input logic arst_n,
	oes_in_if.sink    in_ch,
	oes_out_if.source out_ch
);
	import oes_pkg::*;

	oes_cmd_t cmd;
	oes_sts_t sts;

	oes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_last   (in_ch.last_item),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	oes_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (in_ch.value),
		.sts        (sts),
		.pass_count (out_ch.pass_count),
		.overflow   (out_ch.overflow)
	);

endmodule

[design/oes_datapath.sv]
// Element store, parallel compare-and-swap row, counters and result register.
module oes_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  oes_pkg::oes_cmd_t   cmd,
	input  oes_pkg::value_t     value,
	output oes_pkg::oes_sts_t   sts,
	output oes_pkg::pass_count_t pass_count,
	output logic                overflow
);
	import oes_pkg::*;

	elem_t       elem_q [MAX_ELEMENTS];
	count_t      count_q;
	count_t      passes_q;
	logic        ovf_q;
	pass_count_t res_count_q;
	logic        res_ovf_q;

	logic [MAX_ELEMENTS-1:0] gt;
	logic [MAX_ELEMENTS-1:0] sw;
	logic                    in_order;
	logic                    has_room;

	assign has_room = count_q < count_t'(MAX_ELEMENTS);

	genvar j;
	generate
		for (j = 0; j < MAX_ELEMENTS; j++) begin : g_cmp
			if (j < MAX_ELEMENTS - 1) begin : g_pair
				assign gt[j] = (count_t'(j + 1) < count_q) && (elem_q[j] > elem_q[j+1]);
				assign sw[j] = gt[j] && (passes_q[0] == 1'(j % 2));
			end else begin : g_end
				assign gt[j] = 1'b0;
				assign sw[j] = 1'b0;
			end
		end
	endgenerate

	assign in_order = ~|gt;
	assign sts.done = in_order || (passes_q >= count_q);

	generate
		for (j = 0; j < MAX_ELEMENTS; j++) begin : g_elem
			logic from_hi;
			logic from_lo;
			if (j < MAX_ELEMENTS - 1) begin : g_hi
				assign from_hi = sw[j];
			end else begin : g_nohi
				assign from_hi = 1'b0;
			end
			if (j > 0) begin : g_lo
				assign from_lo = sw[j-1];
			end else begin : g_nolo
				assign from_lo = 1'b0;
			end

			always_ff @(posedge clk) begin
				if (cmd.load && has_room && (count_q[IDX_W-1:0] == IDX_W'(j))) begin
					elem_q[j] <= elem_t'(value);
				end else if (cmd.pass) begin
					if (from_hi) begin
						elem_q[j] <= elem_q[(j + 1) % MAX_ELEMENTS];
					end else if (from_lo) begin
						elem_q[j] <= elem_q[(j + MAX_ELEMENTS - 1) % MAX_ELEMENTS];
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			passes_q <= '0;
			ovf_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (has_room) begin
					count_q <= count_q + count_t'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.start) begin
				passes_q <= '0;
			end else if (cmd.pass) begin
				passes_q <= passes_q + count_t'(1);
			end
			if (cmd.finish) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	// saturate the pass count to the result field
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_count_q <= (32'(passes_q) > 32'(PASS_MAX)) ? pass_count_t'(PASS_MAX)
			                                               : pass_count_t'(passes_q);
			res_ovf_q   <= ovf_q;
		end
	end

	assign pass_count = res_count_q;
	assign overflow   = res_ovf_q;

endmodule

[design/oes_ctrl.sv]
// Load and sort sequencer with the result valid flag.
module oes_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  oes_pkg::oes_sts_t sts,
	output oes_pkg::oes_cmd_t cmd
);
	import oes_pkg::*;

	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_SORT = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic accept;
	logic out_free;

	assign in_ready  = (state_q == ST_LOAD);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		cmd.load   = accept;
		cmd.start  = accept && in_last;
		case (state_q)
			ST_LOAD: begin
				if (cmd.start) begin
					state_d = ST_SORT;
				end
			end
			ST_SORT: begin
				if (!sts.done) begin
					cmd.pass = 1'b1;
				end else if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
